/* src/wrrbp_pkg.sv */
// ----------------------------------------------------------------------------
// wrrbp_pkg: shared types and constants of the backend picker
// Field widths, command and register codes, and the table entry and hit
// count word layouts.
// ----------------------------------------------------------------------------
package wrrbp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned HOST_W   = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // command field
  localparam logic CMD_LOAD = 1'b0;

  // register select, paddr[2]
  localparam logic REG_DEFAULT_HOST   = 1'b0;
  localparam logic REG_ENTRIES_IN_USE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PICKED    = 2'd0,
    ST_LOADED    = 2'd1,
    ST_NO_SERVER = 2'd2
  } status_e;

  typedef struct packed {
    logic [HOST_W-1:0]   host;
    logic [ADDR_W-1:0]   address;
    logic [PORT_W-1:0]   port;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  typedef struct packed {
    logic                exhausted;
    logic [WEIGHT_W-1:0] hit;
  } count_t;

  // result of evaluating one table slot against the scanned host
  typedef struct packed {
    logic   host_match;
    logic   qualify;
    count_t next;
  } eval_t;

endpackage

/* src/wrrbp_in_if.sv */
// ----------------------------------------------------------------------------
// wrrbp_in_if: request channel
// valid/ready channel carrying one load or pick word.
// ----------------------------------------------------------------------------
interface wrrbp_in_if;
  import wrrbp_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SLOT_W-1:0]   entry_index;
  logic [HOST_W-1:0]   host_id;
  logic [ADDR_W-1:0]   server_address;
  logic [PORT_W-1:0]   server_port;
  logic [WEIGHT_W-1:0] entry_weight;

  modport source (
    output valid, cmd, entry_index, host_id, server_address, server_port, entry_weight,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_index, host_id, server_address, server_port, entry_weight,
    output ready
  );
endinterface

/* src/wrrbp_out_if.sv */
// ----------------------------------------------------------------------------
// wrrbp_out_if: response channel
// valid/ready channel carrying one status word per request.
// ----------------------------------------------------------------------------
interface wrrbp_out_if;
  import wrrbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   picked_index;
  logic [ADDR_W-1:0]   picked_address;
  logic [PORT_W-1:0]   picked_port;

  modport source (
    output valid, status, picked_index, picked_address, picked_port,
    input  ready
  );

  modport sink (
    input  valid, status, picked_index, picked_address, picked_port,
    output ready
  );
endinterface

/* src/wrrbp_ram.sv */
// ----------------------------------------------------------------------------
// wrrbp_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wrrbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = wrrbp_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/wrrbp_slot_eval.sv */
// ----------------------------------------------------------------------------
// wrrbp_slot_eval: slot compare unit
// Compares one table slot against the scanned host, checks hit count
// against weight, and forms the incremented count.
// ----------------------------------------------------------------------------
module wrrbp_slot_eval (
  input  wrrbp_pkg::entry_t              entry_i,
  input  wrrbp_pkg::count_t              count_i,
  input  logic [wrrbp_pkg::HOST_W-1:0]   host_i,
  output wrrbp_pkg::eval_t               eval_o
);
  import wrrbp_pkg::*;

  logic                match;
  logic [WEIGHT_W-1:0] hit_inc;

  assign match   = (entry_i.host == host_i);
  assign hit_inc = count_i.hit + WEIGHT_W'(1);

  assign eval_o.host_match     = match;
  assign eval_o.qualify        = match && !count_i.exhausted && (count_i.hit < entry_i.weight);
  assign eval_o.next.hit       = hit_inc;
  assign eval_o.next.exhausted = (hit_inc == entry_i.weight);

endmodule

/* src/weighted_round_robin_backend_pick.sv */
// ----------------------------------------------------------------------------
// weighted_round_robin_backend_pick: weighted round-robin backend selector
// Backend table with per-slot hit counts, driven by a small scan sequencer.
// ----------------------------------------------------------------------------
// A load word writes one table slot (host, address, port, weight) and clears
// its hit count; its response comes the cycle after acceptance. A pick word
// runs up to four scans over slots 0 .. n-1, with n = entries_in_use capped
// at TABLE_ENTRIES: a presence scan for the requested host (falling back to
// default_host), a search for the first slot below its weight, and, if none,
// a clear of that host's counts and a second search. Each scan reads one slot
// per cycle from the table RAM and the hit count RAM (both single read port,
// registered read) through one shared compare unit. A scan that runs to the
// end reads n slots, checks the data of each read the cycle after it and then
// sees the scan end once no read is left in flight. The slowest picks are a
// round restart or no server, which add the clear and a second search. One
// word is in flight at a time; the request side is ready only when the
// previous response has been taken, so the next word goes in the cycle after
// the response handshake. Hit counts need no clear after reset: a valid bit
// per slot, cleared by reset, marks a count as zero until a pick writes it.
// Table slots read undefined until loaded.
// Configuration (APB, pready tied high): default_host at 0x0, entries_in_use
// at 0x4; paddr[1:0] are ignored.
// ----------------------------------------------------------------------------
module weighted_round_robin_backend_pick #(
  parameter int unsigned TABLE_ENTRIES = wrrbp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wrrbp_in_if.sink                     req_i,
  wrrbp_out_if.source                  rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wrrbp_pkg::APB_AW-1:0] paddr,
  input  logic [wrrbp_pkg::APB_DW-1:0] pwdata,
  output logic [wrrbp_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);
  import wrrbp_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  // common width for slot numbers seen on the ports and inside the table
  localparam int unsigned XW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRESENT,
    S_FIND,
    S_CLEAR,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [HOST_W-1:0]   host_q, host_d;        // host being scanned
  logic [CNT_W-1:0]    n_q, n_d;              // scan limit of this pick
  logic [CNT_W-1:0]    ptr_q, ptr_d;          // next slot to read
  logic                chk_vld_q, chk_vld_d;  // read data in flight
  logic [IDX_W-1:0]    chk_idx_q, chk_idx_d;  // slot of the read data
  logic                second_q, second_d;    // counts already cleared once
  logic                cnt_vld_q [TABLE_ENTRIES];
  logic                cnt_vld_d [TABLE_ENTRIES];
  logic [HOST_W-1:0]   dflt_host_q, dflt_host_d;
  logic [LIMIT_W-1:0]  eiu_q, eiu_d;
  logic                rsp_vld_q, rsp_vld_d;
  status_e             rsp_status_q, rsp_status_d;
  logic [SLOT_W-1:0]   rsp_idx_q, rsp_idx_d;
  logic [ADDR_W-1:0]   rsp_addr_q, rsp_addr_d;
  logic [PORT_W-1:0]   rsp_port_q, rsp_port_d;

  logic                ent_we;
  entry_t              ent_wdata;
  entry_t              ent_rdata;
  logic                cnt_we;
  count_t              cnt_rdata;
  count_t              cnt_eff;
  logic                rd_en;
  eval_t               ev;

  logic                acc_req;
  logic                acc_rsp;
  logic                apb_wr;
  logic                issue;
  logic                pass_end;
  logic                ld_in_range;
  logic [XW-1:0]       ld_idx_x;
  logic [XW-1:0]       chk_idx_x;
  logic [31:0]         lim;
  logic [CNT_W-1:0]    lim_n;

  assign acc_req = req_i.valid && req_i.ready;
  assign acc_rsp = rsp_o.valid && rsp_o.ready;
  assign apb_wr  = psel && penable && pwrite && pready;

  assign ld_idx_x    = XW'(req_i.entry_index);
  assign ld_in_range = (32'(req_i.entry_index) < 32'(TABLE_ENTRIES));
  assign chk_idx_x   = XW'(chk_idx_q);

  // entries_in_use saturates at the table size
  assign lim   = (32'(eiu_q) > 32'(TABLE_ENTRIES)) ? 32'(TABLE_ENTRIES) : 32'(eiu_q);
  assign lim_n = lim[CNT_W-1:0];

  assign ent_wdata.host    = req_i.host_id;
  assign ent_wdata.address = req_i.server_address;
  assign ent_wdata.port    = req_i.server_port;
  assign ent_wdata.weight  = req_i.entry_weight;

  // backend table: loads write, scans read
  wrrbp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ld_idx_x[IDX_W-1:0]),
    .wdata_i (ent_wdata),
    .re_i    (rd_en),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (ent_rdata)
  );

  // hit counts: written only by a successful pick
  wrrbp_ram #(
    .WIDTH ($bits(count_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (chk_idx_q),
    .wdata_i (ev.next),
    .re_i    (rd_en),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (cnt_rdata)
  );

  // a count without its valid bit reads as zero
  assign cnt_eff = cnt_vld_q[chk_idx_q] ? cnt_rdata : '0;

  wrrbp_slot_eval u_eval (
    .entry_i (ent_rdata),
    .count_i (cnt_eff),
    .host_i  (host_q),
    .eval_o  (ev)
  );

  always_comb begin
    state_d      = state_q;
    host_d       = host_q;
    n_d          = n_q;
    ptr_d        = ptr_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    second_d     = second_q;
    cnt_vld_d    = cnt_vld_q;
    dflt_host_d  = dflt_host_q;
    eiu_d        = eiu_q;
    rsp_vld_d    = rsp_vld_q;
    rsp_status_d = rsp_status_q;
    rsp_idx_d    = rsp_idx_q;
    rsp_addr_d   = rsp_addr_q;
    rsp_port_d   = rsp_port_q;
    ent_we       = 1'b0;
    cnt_we       = 1'b0;
    rd_en        = 1'b0;

    issue    = (ptr_q < n_q);
    pass_end = !issue && !chk_vld_q;

    // scan engine: one slot read per cycle, checked the cycle after
    if (state_q == S_PRESENT || state_q == S_FIND || state_q == S_CLEAR) begin
      if (issue) begin
        rd_en     = 1'b1;
        ptr_d     = ptr_q + CNT_W'(1);
        chk_vld_d = 1'b1;
        chk_idx_d = ptr_q[IDX_W-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (acc_req) begin
          if (req_i.cmd == CMD_LOAD) begin
            if (ld_in_range) begin
              ent_we                          = 1'b1;
              cnt_vld_d[ld_idx_x[IDX_W-1:0]] = 1'b0;
            end
            rsp_vld_d    = 1'b1;
            rsp_status_d = ST_LOADED;
            rsp_idx_d    = '0;
            rsp_addr_d   = '0;
            rsp_port_d   = '0;
            state_d      = S_RESP;
          end else begin
            host_d   = req_i.host_id;
            n_d      = lim_n;
            ptr_d    = '0;
            second_d = 1'b0;
            state_d  = S_PRESENT;
          end
        end
      end
      S_PRESENT: begin
        if (chk_vld_q && ev.host_match) begin
          // requested host exists; restart from slot zero
          ptr_d     = '0;
          chk_vld_d = 1'b0;
          state_d   = S_FIND;
        end else if (pass_end) begin
          host_d  = dflt_host_q;
          ptr_d   = '0;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if (chk_vld_q && ev.qualify) begin
          cnt_we               = 1'b1;
          cnt_vld_d[chk_idx_q] = 1'b1;
          chk_vld_d            = 1'b0;
          rsp_vld_d            = 1'b1;
          rsp_status_d         = ST_PICKED;
          rsp_idx_d            = chk_idx_x[SLOT_W-1:0];
          rsp_addr_d           = ent_rdata.address;
          rsp_port_d           = ent_rdata.port;
          state_d              = S_RESP;
        end else if (pass_end) begin
          ptr_d = '0;
          if (second_q) begin
            rsp_vld_d    = 1'b1;
            rsp_status_d = ST_NO_SERVER;
            rsp_idx_d    = '0;
            rsp_addr_d   = '0;
            rsp_port_d   = '0;
            state_d      = S_RESP;
          end else begin
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        // new round for this host: drop its counts
        if (chk_vld_q && ev.host_match) begin
          cnt_vld_d[chk_idx_q] = 1'b0;
        end
        if (pass_end) begin
          ptr_d    = '0;
          second_d = 1'b1;
          state_d  = S_FIND;
        end
      end
      S_RESP: begin
        if (acc_rsp) begin
          rsp_vld_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (apb_wr) begin
      if (paddr[2] == REG_ENTRIES_IN_USE) begin
        eiu_d = pwdata[LIMIT_W-1:0];
      end else begin
        dflt_host_d = pwdata[HOST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      host_q       <= '0;
      n_q          <= '0;
      ptr_q        <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      second_q     <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        cnt_vld_q[i] <= 1'b0;
      end
      dflt_host_q  <= '0;
      eiu_q        <= '0;
      rsp_vld_q    <= 1'b0;
      rsp_status_q <= ST_PICKED;
      rsp_idx_q    <= '0;
      rsp_addr_q   <= '0;
      rsp_port_q   <= '0;
    end else begin
      state_q      <= state_d;
      host_q       <= host_d;
      n_q          <= n_d;
      ptr_q        <= ptr_d;
      chk_vld_q    <= chk_vld_d;
      chk_idx_q    <= chk_idx_d;
      second_q     <= second_d;
      cnt_vld_q    <= cnt_vld_d;
      dflt_host_q  <= dflt_host_d;
      eiu_q        <= eiu_d;
      rsp_vld_q    <= rsp_vld_d;
      rsp_status_q <= rsp_status_d;
      rsp_idx_q    <= rsp_idx_d;
      rsp_addr_q   <= rsp_addr_d;
      rsp_port_q   <= rsp_port_d;
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.picked_index   = rsp_idx_q;
  assign rsp_o.picked_address = rsp_addr_q;
  assign rsp_o.picked_port    = rsp_port_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEFAULT_HOST) ? APB_DW'(dflt_host_q) : APB_DW'(eiu_q);

`ifndef SYNTHESIS
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !rsp_o.valid)
    else $error("request taken while a response is pending");

  a_check_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (CNT_W'(chk_idx_q) < n_q))
    else $error("scan checked a slot beyond the scan limit");

  a_pick_marks_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |=> cnt_vld_q[$past(chk_idx_q)])
    else $error("picked slot count not marked valid");

  a_no_server_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_NO_SERVER) |->
      (rsp_o.picked_index == '0 && rsp_o.picked_address == '0 && rsp_o.picked_port == '0))
    else $error("no-server response carries a backend");

  a_load_answers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_req && req_i.cmd == CMD_LOAD) |=> (rsp_o.valid && rsp_o.status == ST_LOADED))
    else $error("load word not answered in the next cycle");
`endif

endmodule
